>>> src/led_pattern_generator_defines.svh
// Assertion macros used by the checker file.
`ifndef LED_PATTERN_GENERATOR_DEFINES_SVH
`define LED_PATTERN_GENERATOR_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define LPG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked at every rising clock edge outside reset.
`define LPG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> src/lpg_pkg.sv
package lpg_pkg;

	typedef enum logic [1:0] {
		MODE_SOLID  = 2'd0,
		MODE_BLINK  = 2'd1,
		MODE_DOUBLE = 2'd2,
		MODE_BREATH = 2'd3
	} mode_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RED      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GREEN    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BLUE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL = 3'd4;

	localparam logic [15:0] BLINK_INTERVAL_RESET = 16'd500;
	localparam logic [31:0] DOUBLE_STEP_MS       = 32'd100;
	localparam logic [3:0]  DOUBLE_WRAP          = 4'd8;
	localparam logic [6:0]  RAMP_TOP             = 7'd100;
	localparam logic [6:0]  RAMP_STEP            = 7'd2;

	// x / 100 for x below 25600 equals (x * 5243) >> 19.
	localparam logic [12:0] RECIP_MUL   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam int PROD_W = 15;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		mode_t       mode;
		rgb_t        color;
		logic [15:0] interval;
	} cfg_t;

	typedef struct packed {
		logic s1_go;
		logic s2_free;
		logic s2_go;
	} flow_t;

	typedef struct packed {
		logic              breath;
		rgb_t              color;
		logic [PROD_W-1:0] prod_red;
		logic [PROD_W-1:0] prod_green;
		logic [PROD_W-1:0] prod_blue;
	} stage2_t;

endpackage

>>> src/led_pattern_generator.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid / s_tready  s_tdata: now_ms [31:0]
// m_        out  m_tvalid / m_tready  m_tdata: red_out, green_out, blue_out
// cfg_      in   cfg_we               cfg_index, cfg_wdata
//
// One update is accepted in every cycle unless results back up at the output.
// The input register, the stage after the pattern logic and the output register each
// hold one item, so up to two more items are accepted while a result waits to be taken.
// Updates that cause no result leave the pipe after the first stage.
// Reset clears the configuration to its defaults and all pattern state to zero.
module led_pattern_generator
	import lpg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [31:0]            s_tdata,  // now_ms [31:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [23:0]            m_tdata   // red_out [7:0], green_out [15:8], blue_out [23:16]
);

	cfg_t        cfg;
	logic        ramp_restart;
	flow_t       flow;
	logic        valid_s1;
	logic [31:0] now_s1;
	logic        s2_valid;
	stage2_t     s2_data;
	rgb_t        final_color;
	logic        out_free;

	assign out_free     = !m_tvalid || m_tready;
	assign flow.s2_go   = s2_valid && out_free;
	assign flow.s2_free = !s2_valid || out_free;
	assign flow.s1_go   = valid_s1 && flow.s2_free;
	assign s_tready     = !valid_s1 || flow.s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1 <= s_tdata;
		end
	end

	lpg_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cfg          (cfg),
		.ramp_restart (ramp_restart)
	);

	lpg_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.ramp_restart (ramp_restart),
		.flow         (flow),
		.s1_valid     (valid_s1),
		.s1_now       (now_s1),
		.final_color  (final_color),
		.s2_valid     (s2_valid),
		.s2_data      (s2_data)
	);

	lpg_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.out_free    (out_free),
		.s2_valid    (s2_valid),
		.s2_data     (s2_data),
		.final_color (final_color),
		.out_valid   (m_tvalid),
		.out_data    (m_tdata)
	);

endmodule

>>> src/lpg_cfg_regs.sv
module lpg_cfg_regs
	import lpg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                   cfg,
	output logic                   ramp_restart
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_SOLID;
			cfg_q.color    <= '0;
			cfg_q.interval <= BLINK_INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:     cfg_q.mode        <= mode_t'(cfg_wdata[1:0]);
				REG_RED:      cfg_q.color.red   <= cfg_wdata[7:0];
				REG_GREEN:    cfg_q.color.green <= cfg_wdata[7:0];
				REG_BLUE:     cfg_q.color.blue  <= cfg_wdata[7:0];
				REG_INTERVAL: cfg_q.interval    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
	assign ramp_restart = cfg_we && (cfg_index == REG_MODE)
		&& (mode_t'(cfg_wdata[1:0]) == MODE_BREATH);

endmodule

>>> src/lpg_core.sv
module lpg_core
	import lpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        ramp_restart,
	input  flow_t       flow,
	input  logic        s1_valid,
	input  logic [31:0] s1_now,
	input  rgb_t        final_color,
	output logic        s2_valid,
	output stage2_t     s2_data
);

	logic [31:0] blink_last_q;
	logic        blink_on_q;
	logic [31:0] dbl_last_q;
	logic [3:0]  dbl_cnt_q;
	rgb_t        dbl_color_q;
	logic [6:0]  ramp_lvl_q;
	logic        ramp_fall_q;

	logic        valid_s2;
	stage2_t     data_s2;

	logic        blink_fire;
	logic        dbl_fire;
	logic [3:0]  cnt_inc;
	logic [3:0]  cnt_d;
	logic [6:0]  lvl_d;
	logic        fall_d;
	rgb_t        prev_color;
	logic        emit;
	stage2_t     data_d;

	assign blink_fire = (s1_now - blink_last_q) > {16'd0, cfg.interval};
	assign dbl_fire   = (s1_now - dbl_last_q) > DOUBLE_STEP_MS;
	assign cnt_inc    = dbl_cnt_q + 4'd1;
	assign cnt_d      = (cnt_inc >= DOUBLE_WRAP) ? 4'd0 : cnt_inc;

	// The colour last shown may still sit in the second stage.
	assign prev_color = valid_s2 ? final_color : dbl_color_q;

	always_comb begin
		if (ramp_fall_q) begin
			lvl_d  = (ramp_lvl_q >= RAMP_STEP) ? ramp_lvl_q - RAMP_STEP : 7'd0;
			fall_d = (lvl_d != 7'd0);
		end else begin
			lvl_d  = ramp_lvl_q + RAMP_STEP;
			fall_d = 1'b0;
			if (lvl_d >= RAMP_TOP) begin
				lvl_d  = RAMP_TOP;
				fall_d = 1'b1;
			end
		end
	end

	always_comb begin
		emit              = 1'b0;
		data_d.breath     = 1'b0;
		data_d.color      = cfg.color;
		data_d.prod_red   = PROD_W'(cfg.color.red)   * PROD_W'(lvl_d);
		data_d.prod_green = PROD_W'(cfg.color.green) * PROD_W'(lvl_d);
		data_d.prod_blue  = PROD_W'(cfg.color.blue)  * PROD_W'(lvl_d);
		case (cfg.mode)
			MODE_SOLID: begin
				emit = 1'b1;
			end
			MODE_BLINK: begin
				emit = blink_fire;
				data_d.color = blink_on_q ? '0 : cfg.color;
			end
			MODE_DOUBLE: begin
				emit = dbl_fire;
				case (cnt_inc)
					4'd1, 4'd2: data_d.color = cfg.color;
					4'd3, 4'd4: data_d.color = '0;
					default:    data_d.color = prev_color;
				endcase
			end
			MODE_BREATH: begin
				emit = 1'b1;
				data_d.breath = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_last_q <= '0;
			blink_on_q   <= 1'b0;
			dbl_last_q   <= '0;
			dbl_cnt_q    <= '0;
			dbl_color_q  <= '0;
			ramp_lvl_q   <= '0;
			ramp_fall_q  <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (flow.s2_free) begin
				valid_s2 <= s1_valid && emit;
			end
			if (flow.s2_go) begin
				dbl_color_q <= final_color;
			end
			if (flow.s1_go && (cfg.mode == MODE_BLINK) && blink_fire) begin
				blink_on_q   <= !blink_on_q;
				blink_last_q <= s1_now;
			end
			if (flow.s1_go && (cfg.mode == MODE_DOUBLE) && dbl_fire) begin
				dbl_cnt_q  <= cnt_d;
				dbl_last_q <= s1_now;
			end
			if (ramp_restart) begin
				ramp_lvl_q  <= '0;
				ramp_fall_q <= 1'b0;
			end else if (flow.s1_go && (cfg.mode == MODE_BREATH)) begin
				ramp_lvl_q  <= lvl_d;
				ramp_fall_q <= fall_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flow.s1_go) begin
			data_s2 <= data_d;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_data  = data_s2;

endmodule

>>> src/lpg_scale.sv
module lpg_scale
	import lpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_free,
	input  logic        s2_valid,
	input  stage2_t     s2_data,
	output rgb_t        final_color,
	output logic        out_valid,
	output logic [23:0] out_data
);

	localparam int QW = PROD_W + $bits(RECIP_MUL);

	logic [QW-1:0] q_red;
	logic [QW-1:0] q_green;
	logic [QW-1:0] q_blue;
	logic          valid_q;
	rgb_t          color_q;

	assign q_red   = QW'(s2_data.prod_red)   * QW'(RECIP_MUL);
	assign q_green = QW'(s2_data.prod_green) * QW'(RECIP_MUL);
	assign q_blue  = QW'(s2_data.prod_blue)  * QW'(RECIP_MUL);

	always_comb begin
		if (s2_data.breath) begin
			final_color.red   = q_red[RECIP_SHIFT +: 8];
			final_color.green = q_green[RECIP_SHIFT +: 8];
			final_color.blue  = q_blue[RECIP_SHIFT +: 8];
		end else begin
			final_color = s2_data.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_valid) begin
			color_q <= final_color;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {color_q.blue, color_q.green, color_q.red};

endmodule

>>> src/lpg_checker.sv
`include "led_pattern_generator_defines.svh"

module lpg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic in_acc;

	assign in_acc = s_tvalid && s_tready;

	// A stalled result keeps its colour.
	`LPG_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")

	// Input is refused only while a result is backed up at the output.
	`LPG_ASSERT_IMP(a_no_idle_block, !s_tready, m_tvalid && !m_tready, "input refused with output free")

	// A result that appears at an empty output went through the input register and the second stage unstalled.
	`LPG_ASSERT_IMP(a_rise_latency, $rose(m_tvalid), $past(in_acc, 3), "result without a matching item")

endmodule

bind led_pattern_generator lpg_checker u_lpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/led_pattern_generator_tb.sv
`timescale 1ns / 100ps

module led_pattern_generator_tb;
	import lpg_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	class led_scoreboard;
		mode_t       mode;
		rgb_t        colour;
		logic [15:0] interval;
		logic [31:0] blink_t;
		bit          blink_lit;
		logic [31:0] dbl_t;
		logic [3:0]  dbl_count;
		rgb_t        shown;
		int unsigned ramp;
		bit          ramp_down;
		rgb_t        pending[$];
		int          errors;
		int          checked;

		function new();
			mode = MODE_SOLID;
			colour = '0;
			interval = BLINK_INTERVAL_RESET;
			blink_t = '0;
			blink_lit = 1'b0;
			dbl_t = '0;
			dbl_count = '0;
			shown = '0;
			ramp = 0;
			ramp_down = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function void report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_MODE: begin
					mode = mode_t'(val[1:0]);
					if (mode == MODE_BREATH) begin
						ramp = 0;
						ramp_down = 1'b0;
					end
				end
				REG_RED:      colour.red = val[7:0];
				REG_GREEN:    colour.green = val[7:0];
				REG_BLUE:     colour.blue = val[7:0];
				REG_INTERVAL: interval = val;
				default: ;
			endcase
		endfunction

		function void show(rgb_t c);
			shown = c;
			pending.push_back(c);
		endfunction

		function void note_update(logic [31:0] now);
			logic [31:0] diff;
			rgb_t        c;
			case (mode)
				MODE_SOLID: show(colour);
				MODE_BLINK: begin
					diff = now - blink_t;
					if (diff > {16'd0, interval}) begin
						blink_lit = !blink_lit;
						blink_t = now;
						show(blink_lit ? colour : rgb_t'('0));
					end
				end
				MODE_DOUBLE: begin
					diff = now - dbl_t;
					if (diff > DOUBLE_STEP_MS) begin
						c = shown;
						dbl_count = dbl_count + 4'd1;
						if (dbl_count == 4'd1 || dbl_count == 4'd2)
							c = colour;
						else if (dbl_count == 4'd3 || dbl_count == 4'd4)
							c = '0;
						else if (dbl_count >= DOUBLE_WRAP)
							dbl_count = '0;
						dbl_t = now;
						show(c);
					end
				end
				default: begin
					if (ramp_down) begin
						ramp = (ramp >= RAMP_STEP) ? ramp - RAMP_STEP : 0;
						if (ramp == 0)
							ramp_down = 1'b0;
					end else begin
						ramp = ramp + RAMP_STEP;
						if (ramp >= RAMP_TOP) begin
							ramp = RAMP_TOP;
							ramp_down = 1'b1;
						end
					end
					c.red = 8'((int'(colour.red) * ramp) / RAMP_TOP);
					c.green = 8'((int'(colour.green) * ramp) / RAMP_TOP);
					c.blue = 8'((int'(colour.blue) * ramp) / RAMP_TOP);
					show(c);
				end
			endcase
		endfunction

		function void check_result(logic [23:0] data);
			rgb_t want;
			if (pending.size() == 0) begin
				report($sformatf("result %h with nothing expected", data));
			end else begin
				want = pending.pop_front();
				checked++;
				if (data[7:0] !== want.red)
					report($sformatf("red %h, expected %h", data[7:0], want.red));
				if (data[15:8] !== want.green)
					report($sformatf("green %h, expected %h", data[15:8], want.green));
				if (data[23:16] !== want.blue)
					report($sformatf("blue %h, expected %h", data[23:16], want.blue));
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [23:0]            m_tdata;

	led_scoreboard sb = new();
	bit            calm = 1'b0;
	logic [31:0]   clock_ms = '0;
	int            updates_sent = 0;
	int            phases_run = 0;
	int            cycles = 0;

	led_pattern_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[led_pattern_generator] ERROR");
			$finish;
		end
	end

	task automatic send(logic [31:0] now);
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= now;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_update(now);
		clock_ms = now;
		updates_sent++;
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
	endtask

	task automatic drain_pipe();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [15:0] pick_interval();
		case ($urandom_range(3))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(1, 300));
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [31:0] next_time();
		int unsigned pick;
		logic [31:0] gap;
		logic [31:0] base;
		pick = $urandom_range(99);
		case (sb.mode)
			MODE_BLINK: begin
				gap = {16'd0, sb.interval};
				base = sb.blink_t;
			end
			MODE_DOUBLE: begin
				gap = DOUBLE_STEP_MS;
				base = sb.dbl_t;
			end
			default: begin
				gap = 32'd400;
				base = clock_ms;
			end
		endcase
		if (pick < 10)
			return $urandom;
		if (pick < 20)
			return clock_ms;
		if (pick < 60 && (sb.mode == MODE_BLINK || sb.mode == MODE_DOUBLE))
			return base + gap + $urandom_range(0, 2);
		return clock_ms + $urandom_range(0, gap / 2 + 1);
	endfunction

	initial begin
		mode_t       m;
		int          run_len;
		logic [31:0] base;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(32'd0);
		drain_pipe();
		cfg_write(REG_RED, 16'h00FF);
		cfg_write(REG_GREEN, 16'h3A00);
		cfg_write(REG_BLUE, 16'h0055);
		end_writes();
		send(32'hFFFF_FFFF);

		drain_pipe();
		cfg_write(REG_MODE, 16'hFFFD);
		cfg_write(REG_INTERVAL + 3'd1, 16'hFFFF);
		cfg_write(REG_INTERVAL + 3'd3, 16'h0000);
		end_writes();
		send(32'd500);
		send(32'd501);
		send(32'd1001);
		send(32'd1002);
		send(32'hFFFF_FF00);
		send(32'h0000_0010);

		drain_pipe();
		cfg_write(REG_INTERVAL, 16'd0);
		end_writes();
		send(32'h0000_0010);
		send(32'h0000_0011);

		drain_pipe();
		cfg_write(REG_MODE, {14'd0, MODE_DOUBLE});
		end_writes();
		base = 32'h0000_1000;
		for (int k = 1; k <= 9; k++)
			send(base + k * 101);
		send(base + 9 * 101 + 100);

		drain_pipe();
		cfg_write(REG_MODE, {14'h2A5, MODE_BREATH});
		end_writes();
		repeat (3) send(clock_ms + 1);
		drain_pipe();
		cfg_write(REG_MODE, {14'd0, MODE_BREATH});
		end_writes();
		repeat (2) send(clock_ms + 1);

		while (updates_sent < 380) begin
			drain_pipe();
			m = (phases_run < 4) ? mode_t'(phases_run) : mode_t'($urandom_range(3));
			if (m != sb.mode || $urandom_range(1) == 1)
				cfg_write(REG_MODE, {14'($urandom_range(16383)), m});
			if ($urandom_range(1) == 1)
				cfg_write(REG_RED, {8'($urandom_range(255)), pick_level()});
			if ($urandom_range(1) == 1)
				cfg_write(REG_GREEN, {8'($urandom_range(255)), pick_level()});
			if ($urandom_range(1) == 1)
				cfg_write(REG_BLUE, {8'($urandom_range(255)), pick_level()});
			if (m == MODE_BLINK || $urandom_range(3) == 0)
				cfg_write(REG_INTERVAL, pick_interval());
			if ($urandom_range(7) == 0)
				cfg_write(REG_INTERVAL + 3'($urandom_range(1, 3)), 16'($urandom));
			end_writes();
			calm = (phases_run == 3);
			run_len = (m == MODE_BREATH) ? 110 : $urandom_range(30, 50);
			if (calm)
				run_len = 80;
			repeat (run_len) send(next_time());
			calm = 1'b0;
			phases_run++;
		end

		drain_pipe();
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
		$display("Sent %0d updates over %0d random setting phases, all four modes included.",
			updates_sent, phases_run);
		$display("Checked %0d colour results, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("[led_pattern_generator] OK");
		else
			$display("[led_pattern_generator] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/lpg_pkg.sv
src/lpg_cfg_regs.sv
src/lpg_core.sv
src/lpg_scale.sv
src/led_pattern_generator.sv
src/lpg_checker.sv
tb/led_pattern_generator_tb.sv
